>>> hw/rtl/mtws_pkg.sv
// mtws_pkg: shared types and constants for the mt19937 word source
// no dependencies

package mtws_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned IDX_W        = 10;

  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] MATRIX_VEC = 32'h9908b0df;
  localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C   = 32'hefc60000;
  localparam logic [31:0] SEED_RESET = 32'd5489;

  localparam logic [1:0] FUNC_RAW  = 2'd0;
  localparam logic [1:0] FUNC_HALF = 2'd1;
  localparam logic [1:0] FUNC_MOD  = 2'd2;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_DRAW,
    ST_DIV,
    ST_OUT
  } mtws_state_t;

  // control from sequencer to the cell chain
  typedef struct packed {
    logic shift;      // rotate the chain by one word
    logic seed_load;  // replace the head word with the seed recurrence value
    logic twist;      // replace the head word with its twisted value
  } mtws_chain_ctl_t;

  function automatic logic [31:0] temper(input logic [31:0] y_in);
    logic [31:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

>>> hw/rtl/mtws_cell.sv
// mtws_cell: one 32-bit word cell of the rotating state chain
// depends on mtws_pkg

module mtws_cell (
  input  logic        clk,
  input  logic        shift,
  input  logic [31:0] word_in,
  output logic [31:0] word_out
);

  logic [31:0] word_r;

  // take the neighbor's word on each shift
  always_ff @(posedge clk) begin
    if (shift) begin
      word_r <= word_in;
    end
  end

  assign word_out = word_r;

endmodule

>>> hw/rtl/mtws_chain.sv
// mtws_chain: ring of 624 word cells with the seed and twist update at the head
// depends on mtws_pkg, mtws_cell

module mtws_chain (
  input  logic                      clk,
  input  mtws_pkg::mtws_chain_ctl_t ctl,
  input  logic [31:0]               seed_word,
  input  logic [mtws_pkg::IDX_W-1:0] seed_idx,
  output logic [31:0]               twist_word
);

  localparam int unsigned N = mtws_pkg::STATE_WORDS;

  logic [31:0] tap [N];
  logic [31:0] feed;
  logic [31:0] prev_r;
  logic [31:0] y;
  logic [31:0] mixed;
  logic [31:0] seed_calc;
  logic [31:0] prod_r;

  // cells: cell 0 is the head, cell N-1 takes the new word
  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == N - 1) begin : g_tail
      mtws_cell u_cell (.clk(clk), .shift(ctl.shift), .word_in(feed), .word_out(tap[g]));
    end else begin : g_body
      mtws_cell u_cell (.clk(clk), .shift(ctl.shift), .word_in(tap[g+1]),
                        .word_out(tap[g]));
    end
  end

  // twisted head word, the next word to be drawn
  assign twist_word = mixed;

  // twist of the head word with its neighbor and the offset tap
  assign y     = {tap[0][31], tap[1][30:0]};
  assign mixed = tap[mtws_pkg::TWIST_OFFSET] ^ (y >> 1) ^
                 (y[0] ? mtws_pkg::MATRIX_VEC : 32'd0);

  // seed recurrence uses the previously emitted word, product is registered
  always_ff @(posedge clk) begin
    if (ctl.seed_load) begin
      prev_r <= seed_calc;
    end
  end
  always_ff @(posedge clk) begin
    prod_r <= mtws_pkg::INIT_MULT * (prev_r ^ (prev_r >> 30));
  end
  assign seed_calc = (seed_idx == '0) ? seed_word :
                     prod_r + {{(32-mtws_pkg::IDX_W){1'b0}}, seed_idx};

  always_comb begin
    priority if (ctl.seed_load) begin
      feed = seed_calc;
    end else if (ctl.twist) begin
      feed = mixed;
    end else begin
      feed = tap[0];
    end
  end

endmodule

>>> hw/rtl/mtws_divider.sv
// mtws_divider: restoring divider, one quotient bit per cycle, remainder only
// depends on mtws_pkg

module mtws_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [30:0] div_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] trial;

  assign trial = {rem_r, quo_r[31]} - {2'b0, div_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
      end
      quo_nxt = {quo_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done      = busy_r && (cnt_r == 6'd1);
  assign remainder = rem_nxt;

endmodule

>>> hw/rtl/mersenne_twister_word_source_top.sv
// mersenne_twister_word_source_top: mt19937 word source top level
// depends on mtws_pkg, mtws_chain, mtws_divider
//
// Usage: each request on in_* (func, bound) draws one tempered MT19937 word
// and returns one result on out_* (value, bad_bound). The seed register is
// written through cfg_wr_en/cfg_wr_data; reset loads seed 5489.
// After reset or a seed write, the next request first rebuilds the state:
// the 624 words pass through the head of the cell ring, each one after
// an even phase that lets the registered seed multiply settle.
// Draws: the state is a ring of 624 cells rotated one word per draw; the
// head word is twisted in place as it leaves, so no bulk regeneration.
// A result goes from the draw state to the output register for modes 0,
// 1 and 3 and for a zero bound; mode 2 first waits in the divide state
// (bit-serial remainder, 32 steps). No new request is taken meanwhile.
// One request is in flight at a time. The result is held in the output
// register until out_tready; in_tready stays low until it is taken.
// A zero bound in mode 2 gives value 0 with bad_bound set.

module mersenne_twister_word_source_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [1:0] func, [32:2] bound, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] value, [32] bad_bound, zero fill
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  localparam int unsigned IW = mtws_pkg::IDX_W;
  localparam logic [IW-1:0] LAST = IW'(mtws_pkg::STATE_WORDS - 1);

  mtws_pkg::mtws_state_t  state_r, state_nxt;
  mtws_pkg::mtws_chain_ctl_t ctl;

  logic [31:0]   seed_r;
  logic          pend_r;
  logic [IW-1:0] sidx_r;
  logic          sphase_r;
  logic [1:0]    func_r;
  logic [30:0]   bound_r;
  logic [31:0]   value_r;
  logic          bad_r;
  logic [31:0]   twist_word;
  logic [31:0]   draw_word;
  logic          div_start, div_done;
  logic [31:0]   div_rem;
  logic          take;

  assign take = in_tvalid && in_tready;

  mtws_chain u_chain (
    .clk(clk), .ctl(ctl), .seed_word(seed_r), .seed_idx(sidx_r), .twist_word(twist_word)
  );

  // the word drawn is the tempered twisted head
  assign draw_word = mtws_pkg::temper(twist_word);

  mtws_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(draw_word),
    .divisor(bound_r), .done(div_done), .remainder(div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mtws_pkg::ST_IDLE: if (take) state_nxt = pend_r ? mtws_pkg::ST_SEED : mtws_pkg::ST_DRAW;
      mtws_pkg::ST_SEED: if (sphase_r && sidx_r == LAST) state_nxt = mtws_pkg::ST_DRAW;
      mtws_pkg::ST_DRAW: begin
        if (func_r == mtws_pkg::FUNC_MOD && bound_r != '0) state_nxt = mtws_pkg::ST_DIV;
        else state_nxt = mtws_pkg::ST_OUT;
      end
      mtws_pkg::ST_DIV:  if (div_done) state_nxt = mtws_pkg::ST_OUT;
      mtws_pkg::ST_OUT:  if (out_tready) state_nxt = mtws_pkg::ST_IDLE;
      default:           state_nxt = mtws_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctl.shift     = 1'b0;
    ctl.seed_load = 1'b0;
    ctl.twist     = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      mtws_pkg::ST_SEED: begin
        ctl.seed_load = sphase_r;
        ctl.shift     = sphase_r;
      end
      mtws_pkg::ST_DRAW: begin
        ctl.shift = 1'b1;
        ctl.twist = 1'b1;
        div_start = (func_r == mtws_pkg::FUNC_MOD) && (bound_r != '0);
      end
      default: ;
    endcase
  end

  assign in_tready  = (state_r == mtws_pkg::ST_IDLE);
  assign out_tvalid = (state_r == mtws_pkg::ST_OUT);
  assign out_tdata  = {7'd0, bad_r, value_r};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mtws_pkg::ST_IDLE;
      seed_r   <= mtws_pkg::SEED_RESET;
      pend_r   <= 1'b1;
      sidx_r   <= '0;
      sphase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
        pend_r <= 1'b1;
      end else if (take && pend_r) begin
        pend_r <= 1'b0;
      end
      if (take) begin
        sidx_r   <= '0;
        sphase_r <= 1'b0;
      end else if (state_r == mtws_pkg::ST_SEED) begin
        // even phase lets the registered product settle
        sphase_r <= ~sphase_r;
        if (sphase_r) sidx_r <= sidx_r + IW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      func_r  <= in_tdata[1:0];
      bound_r <= in_tdata[32:2];
    end
    if (state_r == mtws_pkg::ST_DRAW) begin
      unique case (func_r)
        mtws_pkg::FUNC_HALF: begin
          value_r <= draw_word >> 1;
          bad_r   <= 1'b0;
        end
        mtws_pkg::FUNC_MOD: begin
          value_r <= '0;
          bad_r   <= (bound_r == '0);
        end
        default: begin
          value_r <= draw_word;
          bad_r   <= 1'b0;
        end
      endcase
    end else if (state_r == mtws_pkg::ST_DIV && div_done) begin
      value_r <= div_rem;
    end
  end

`ifndef SYNTH
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output both open");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && bad_r) |-> (value_r == 32'd0)) else $error("bad bound with nonzero value");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(value_r)))
    else $error("result changed while stalled");
`endif

endmodule
